FILE: rtl/tpg_pkg.sv
// ============================================================================
// tpg_pkg
// Shared types and constants for the trapezoid profile generator.
// ============================================================================
`default_nettype none

package tpg_pkg;

    // default widths
    localparam int STEP_COUNT_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF       = 16;

    // fixed field widths
    localparam int IN_W    = 32;
    localparam int POS_W   = 48;
    localparam int DW      = 64;   // planner datapath width
    localparam int MUL_AW  = 34;   // multiplier operand widths
    localparam int MUL_BW  = 33;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int SQ_ITER = DW / 2;
    localparam int SQ_CW   = 5;

    localparam logic [IN_W-1:0] ACCEL_SAT = 32'h7FFF_FFFF;

    typedef enum logic
    {
        KIND_START,
        KIND_TICK
    } item_kind_t;

    // queued item
    typedef struct packed
    {
        item_kind_t       kind;
        logic [IN_W-1:0]  distance;
        logic [IN_W-1:0]  velocity_limit;
        logic [IN_W-1:0]  accel_limit;
    } tpg_item_t;

    typedef enum logic [4:0]
    {
        ST_IDLE,
        ST_PLAN0,
        ST_QDIV,
        ST_SQRT,
        ST_SQ_FIX,
        ST_SQ_FIX2,
        ST_VCHK,
        ST_VCHK2,
        ST_T1DIV,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_T2DIV,
        ST_CLAMP,
        ST_DEN1,
        ST_DEN2,
        ST_DEN3,
        ST_ADIV
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/trapezoid_profile_generator_core.sv
// ============================================================================
// trapezoid_profile_generator_core
// Trapezoidal move planner and per-tick motion sample generator.
// ============================================================================
// Usage:
//   Input stream s_*: tuser[0] is the command (0 start a move, 1 tick),
//   tdata carries distance, velocity limit and acceleration limit.
//   A start item produces no output; each tick item produces one sample
//   on m_* (acceleration, velocity, position), with tlast on the final
//   sample of a move and tuser flags idle and error.
//   Items enter a two-entry queue, so the input keeps flowing while the
//   planner or the output is busy.
//   A tick's sample passes through the queue and the output register
//   before it reaches m_*; back-to-back ticks sustain one per cycle while
//   the planner is idle and the receiver is ready. A start occupies the
//   planner for up to four divisions on the shared restoring divider, a
//   square root and multiply steps.
//   Reset clears the move state, the queue and the output valid flag.
//   When the receiver stalls, the sample holds on m_* and ticks wait in
//   the queue; s_tready drops once the queue is full.
// ============================================================================
`default_nettype none

module trapezoid_profile_generator_core
#(
    parameter int STEP_COUNT_BITS = tpg_pkg::STEP_COUNT_BITS_DEF,
    parameter int FRAC_BITS       = tpg_pkg::FRAC_BITS_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [95:0]    s_tdata,   // distance, velocity_limit, accel_limit
    input  wire logic [0:0]     s_tuser,   // command
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [127:0]        m_tdata,   // accel_out, velocity_out, position_out
    output logic [1:0]          m_tuser,   // idle, error
    output logic                m_tlast    // last_sample
);
    import tpg_pkg::*;

    logic       head_valid;
    tpg_item_t  head_item;
    logic       head_pop;

    tpg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    tpg_back
    #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS),
        .FRAC_BITS       (FRAC_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/tpg_front.sv
// ============================================================================
// tpg_front
// Input side: accepts items, decodes the command and queues them.
// ============================================================================
`default_nettype none

module tpg_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [95:0]                    s_tdata,  // distance, velocity_limit, accel_limit
    input  wire logic [0:0]                     s_tuser,  // command
    output logic                                head_valid,
    output tpg_pkg::tpg_item_t                  head_item,
    input  wire logic                           head_pop
);
    import tpg_pkg::*;

    tpg_item_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    tpg_item_t          in_item;
    logic               push;

    // classify the incoming item
    always_comb
    begin
        in_item.kind           = s_tuser[0] ? KIND_TICK : KIND_START;
        in_item.distance       = s_tdata[31:0];
        in_item.velocity_limit = s_tdata[63:32];
        in_item.accel_limit    = s_tdata[95:64];
    end

    assign s_tready   = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // pointer update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = head_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(head_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tpg_div.sv
// ============================================================================
// tpg_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module tpg_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tpg_pkg::DW-1:0]     dividend,
    input  wire logic [tpg_pkg::DW-1:0]     divisor,
    output logic                            done,
    output logic [tpg_pkg::DW-1:0]          quotient
);
    import tpg_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW:0]    rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]  dsr_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DW:0]    trial;

    // one step
    always_comb
    begin
        trial     = {rem_reg[DW-1:0], quo_reg[DW-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/tpg_back.sv
// ============================================================================
// tpg_back
// Move planner sequencer and tick stepper with the output register.
// ============================================================================
`default_nettype none

module tpg_back
#(
    parameter int STEP_COUNT_BITS = tpg_pkg::STEP_COUNT_BITS_DEF,
    parameter int FRAC_BITS       = tpg_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire tpg_pkg::tpg_item_t     head_item,
    output logic                        head_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [127:0]                m_tdata,  // accel_out, velocity_out, position_out
    output logic [1:0]                  m_tuser,  // idle, error
    output logic                        m_tlast   // last_sample
);
    import tpg_pkg::*;

    localparam int RW = STEP_COUNT_BITS;
    localparam int CW = STEP_COUNT_BITS + 1;
    localparam int IW = STEP_COUNT_BITS + 2;
    localparam logic [DW-1:0] RMAX = DW'((64'd1 << RW) - 64'd1);
    localparam logic [DW-1:0] CMAX = DW'((64'd1 << CW) - 64'd1);

    back_state_t        state_reg, state_next;

    // move state
    logic [IN_W-1:0]    step_accel_reg;
    logic [POS_W-1:0]   cur_velocity_reg;
    logic [POS_W-1:0]   cur_position_reg;
    logic [RW-1:0]      ramp_steps_reg;
    logic [CW-1:0]      cruise_steps_reg;
    logic [IW-1:0]      step_index_reg;
    logic [IW-1:0]      rc_end_reg;
    logic [IW-1:0]      total_reg;
    logic               move_active_reg;
    logic               error_flag_reg;

    // planner registers
    logic [IN_W-1:0]    pm_reg, vm_reg, am_reg;
    logic               dneg_reg;
    logic [DW-1:0]      p_reg;
    logic [DW-1:0]      x_reg, r_reg, bit_reg;
    logic [SQ_CW-1:0]   sq_cnt_reg;
    logic [DW-1:0]      t1_reg, t2_reg;
    logic [DW-1:0]      prod_reg;

    // output register
    logic               out_valid_reg;
    logic [127:0]       out_data_reg;
    logic [1:0]         out_user_reg;
    logic               out_last_reg;

    // shared units
    logic               div_start, div_done;
    logic [DW-1:0]      div_dividend, div_divisor, div_quot;
    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic [MUL_AW+MUL_BW-1:0] mul_prod;

    // control
    logic               out_free, do_start, do_tick;
    logic [IN_W-1:0]    pm_in, vm_in, am_in;
    logic [DW-1:0]      sq_sum;
    logic [DW-1:0]      den;
    logic [DW-1:0]      mag_sat;
    logic [IN_W-1:0]    accel_new;
    logic [POS_W-1:0]   acc48, vel_new, pos_new;
    logic [IW-1:0]      idx_new;

    tpg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // magnitudes of the start fields
    assign pm_in = head_item.distance[31] ? -head_item.distance : head_item.distance;
    assign vm_in = head_item.velocity_limit[31] ? -head_item.velocity_limit
                                                : head_item.velocity_limit;
    assign am_in = head_item.accel_limit[31] ? -head_item.accel_limit : head_item.accel_limit;

    assign out_free = !out_valid_reg || m_tready;
    assign do_start = (state_reg == ST_IDLE) && head_valid && (head_item.kind == KIND_START);
    assign do_tick  = (state_reg == ST_IDLE) && head_valid && (head_item.kind == KIND_TICK)
                      && out_free;
    assign head_pop = do_start || do_tick;

    assign sq_sum = r_reg + bit_reg;
    assign den    = x_reg + prod_reg;

    // rounded, saturated acceleration
    always_comb
    begin
        mag_sat   = (div_quot > DW'(ACCEL_SAT)) ? DW'(ACCEL_SAT) : div_quot;
        accel_new = dneg_reg ? -mag_sat[IN_W-1:0] : mag_sat[IN_W-1:0];
    end

    // tick arithmetic
    always_comb
    begin
        idx_new = step_index_reg + 1'b1;
        if (step_index_reg < IW'(ramp_steps_reg))
        begin
            acc48 = {{(POS_W-IN_W){step_accel_reg[IN_W-1]}}, step_accel_reg};
        end
        else if (step_index_reg < rc_end_reg)
        begin
            acc48 = '0;
        end
        else
        begin
            acc48 = -{{(POS_W-IN_W){step_accel_reg[IN_W-1]}}, step_accel_reg};
        end
        vel_new = cur_velocity_reg + acc48;
        pos_new = cur_position_reg + vel_new;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (do_start) state_next = ST_PLAN0;
            ST_PLAN0:   state_next = (am_reg == '0 || pm_reg == '0) ? ST_IDLE : ST_QDIV;
            ST_QDIV:    if (div_done) state_next = ST_SQRT;
            ST_SQRT:    if (sq_cnt_reg == SQ_CW'(SQ_ITER - 1)) state_next = ST_SQ_FIX;
            ST_SQ_FIX:  state_next = ST_SQ_FIX2;
            ST_SQ_FIX2: state_next = ST_VCHK;
            ST_VCHK:    state_next = ST_VCHK2;
            ST_VCHK2:
            begin
                if (DW'(vm_reg) < prod_reg)
                begin
                    state_next = (vm_reg == '0) ? ST_IDLE : ST_T1DIV;
                end
                else
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_T1DIV:   if (div_done) state_next = ST_M1;
            ST_M1:      state_next = ST_M2;
            ST_M2:      state_next = ST_M3;
            ST_M3:      state_next = (prod_reg < p_reg) ? ST_T2DIV : ST_CLAMP;
            ST_T2DIV:   if (div_done) state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_DEN1;
            ST_DEN1:    state_next = ST_DEN2;
            ST_DEN2:    state_next = ST_DEN3;
            ST_DEN3:    state_next = ST_ADIV;
            ST_ADIV:    if (div_done) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // unit control
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_PLAN0:
            begin
                div_start    = (am_reg != '0) && (pm_reg != '0);
                div_dividend = p_reg + DW'(am_reg) - 1'b1;
                div_divisor  = DW'(am_reg);
            end
            ST_SQ_FIX:
            begin
                mul_a = MUL_AW'(r_reg);
                mul_b = MUL_BW'(r_reg);
            end
            ST_VCHK:
            begin
                mul_a = MUL_AW'(am_reg);
                mul_b = MUL_BW'(t1_reg);
            end
            ST_VCHK2:
            begin
                div_start    = (DW'(vm_reg) < prod_reg) && (vm_reg != '0);
                div_dividend = DW'(vm_reg) + DW'(am_reg) - 1'b1;
                div_divisor  = DW'(am_reg);
            end
            ST_M1:
            begin
                mul_a = MUL_AW'(am_reg);
                mul_b = MUL_BW'(t1_reg);
            end
            ST_M2:
            begin
                mul_a = MUL_AW'(prod_reg);
                mul_b = MUL_BW'(t1_reg);
            end
            ST_M3:
            begin
                div_start    = (prod_reg < p_reg);
                div_dividend = p_reg - prod_reg + DW'(vm_reg) - 1'b1;
                div_divisor  = DW'(vm_reg);
            end
            ST_DEN1:
            begin
                mul_a = MUL_AW'(t1_reg);
                mul_b = MUL_BW'(t1_reg);
            end
            ST_DEN2:
            begin
                mul_a = MUL_AW'(t1_reg);
                mul_b = MUL_BW'(t2_reg);
            end
            ST_DEN3:
            begin
                div_start    = 1'b1;
                div_dividend = p_reg + (den >> 1);
                div_divisor  = den;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // full-width product
    assign mul_prod = mul_a * mul_b;

    // multiplier register
    always_ff @(posedge clk)
    begin
        prod_reg <= DW'(mul_prod);
    end

    // planner datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_start)
                begin
                    pm_reg   <= pm_in;
                    vm_reg   <= vm_in;
                    am_reg   <= am_in;
                    dneg_reg <= head_item.distance[31];
                    p_reg    <= DW'(pm_in) << FRAC_BITS;
                end
            end
            ST_QDIV:
            begin
                x_reg      <= div_quot;
                p_reg      <= p_reg;
                r_reg      <= '0;
                bit_reg    <= DW'(1) << (DW - 2);
                sq_cnt_reg <= '0;
                t2_reg     <= '0;
                t1_reg     <= div_quot;
            end
            ST_SQRT:
            begin
                if (x_reg >= sq_sum)
                begin
                    x_reg <= x_reg - sq_sum;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg    <= bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            ST_SQ_FIX2:
            begin
                // t1_reg still holds q here
                t1_reg <= (prod_reg < t1_reg) ? r_reg + 1'b1 : r_reg;
            end
            ST_T1DIV:
            begin
                if (div_done)
                begin
                    t1_reg <= div_quot;
                end
            end
            ST_T2DIV:
            begin
                if (div_done)
                begin
                    t2_reg <= div_quot;
                end
            end
            ST_CLAMP:
            begin
                if (t1_reg > RMAX)
                begin
                    t1_reg <= RMAX;
                end
                if (t2_reg > CMAX)
                begin
                    t2_reg <= CMAX;
                end
            end
            ST_DEN2:
            begin
                x_reg <= prod_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    // move state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_accel_reg   <= '0;
            cur_velocity_reg <= '0;
            cur_position_reg <= '0;
            ramp_steps_reg   <= '0;
            cruise_steps_reg <= '0;
            step_index_reg   <= '0;
            rc_end_reg       <= '0;
            total_reg        <= '0;
            move_active_reg  <= 1'b0;
            error_flag_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (do_start)
            begin
                cur_velocity_reg <= '0;
                cur_position_reg <= '0;
                step_index_reg   <= '0;
                move_active_reg  <= 1'b0;
                step_accel_reg   <= '0;
                ramp_steps_reg   <= '0;
                cruise_steps_reg <= '0;
            end
            if (state_reg == ST_PLAN0)
            begin
                if (am_reg == '0)
                begin
                    error_flag_reg <= 1'b1;
                end
                else if (pm_reg == '0)
                begin
                    error_flag_reg <= 1'b0;
                end
            end
            if (state_reg == ST_VCHK2 && DW'(vm_reg) < prod_reg && vm_reg == '0)
            begin
                error_flag_reg <= 1'b1;
            end
            if (state_reg == ST_ADIV && div_done)
            begin
                step_accel_reg   <= accel_new;
                ramp_steps_reg   <= t1_reg[RW-1:0];
                cruise_steps_reg <= t2_reg[CW-1:0];
                rc_end_reg       <= IW'(t1_reg[RW-1:0]) + IW'(t2_reg[CW-1:0]);
                total_reg        <= {1'b0, t1_reg[RW-1:0], 1'b0} + IW'(t2_reg[CW-1:0]);
                error_flag_reg   <= 1'b0;
                move_active_reg  <= 1'b1;
            end
            if (do_tick)
            begin
                out_valid_reg <= 1'b1;
                if (move_active_reg)
                begin
                    cur_velocity_reg <= vel_new;
                    cur_position_reg <= pos_new;
                    step_index_reg   <= idx_new;
                    if (idx_new >= total_reg)
                    begin
                        move_active_reg <= 1'b0;
                    end
                end
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (do_tick)
        begin
            if (move_active_reg)
            begin
                out_data_reg <= {pos_new, vel_new, acc48[IN_W-1:0]};
                out_user_reg <= 2'b00;
                out_last_reg <= (idx_new >= total_reg);
            end
            else
            begin
                out_data_reg <= {cur_position_reg, cur_velocity_reg, {IN_W{1'b0}}};
                out_user_reg <= {error_flag_reg, 1'b1};
                out_last_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/tpg_checker.sv
// ============================================================================
// tpg_checker
// Port-level checks for the trapezoid profile generator.
// ============================================================================
`default_nettype none

module tpg_checker
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    input  wire logic [127:0]   m_tdata,
    input  wire logic [1:0]     m_tuser,
    input  wire logic           m_tlast
);

    // final sample of a move is never an idle sample
    a_last_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser[0])
        else $error("last sample flagged idle");

    // idle samples carry no acceleration
    a_idle_no_accel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("idle sample with acceleration");

    // error is only reported on idle samples
    a_error_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("error flag on a moving sample");

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed under stall");

endmodule

bind trapezoid_profile_generator_core tpg_checker u_tpg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trapezoid_profile_generator_core: drives start and
// tick items with random gaps and output stalls, predicts every motion sample
// and compares each one field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tpg_pkg::*;

    localparam int RAMP_BITS = STEP_COUNT_BITS_DEF;
    localparam int QBITS     = FRAC_BITS_DEF;

    typedef struct
    {
        logic [31:0] accel;
        logic [47:0] velocity;
        logic [47:0] position;
        logic        last;
        logic        idle;
        logic        err;
    } motion_sample_t;

    // move planner model plus the queue of samples still to come
    class profile_scoreboard;
        logic [31:0]    step_accel;
        logic [47:0]    velocity;
        logic [47:0]    position;
        longint unsigned ramp_len;
        longint unsigned cruise_len;
        longint unsigned tick_index;
        bit             moving;
        bit             err_flag;
        motion_sample_t pending[$];
        int             mismatches;

        function new();
            step_accel = '0;
            velocity   = '0;
            position   = '0;
            ramp_len   = 0;
            cruise_len = 0;
            tick_index = 0;
            moving     = 0;
            err_flag   = 0;
            mismatches = 0;
        endfunction

        function longint unsigned magnitude(logic [31:0] raw);
            return raw[31] ? (64'h1_0000_0000 - {32'h0, raw}) : {32'h0, raw};
        endfunction

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned ticks_left();
            return moving ? (2 * ramp_len + cruise_len - tick_index) : 0;
        endfunction

        function void plan(logic [31:0] distance, logic [31:0] vlim, logic [31:0] alim);
            longint unsigned pm, vm, am, p, q, t1, t2, den, mag;
            pm = magnitude(distance);
            vm = magnitude(vlim);
            am = magnitude(alim);
            t2 = 0;
            velocity   = '0;
            position   = '0;
            tick_index = 0;
            moving     = 0;
            step_accel = '0;
            ramp_len   = 0;
            cruise_len = 0;
            if (am == 0)
            begin
                err_flag = 1;
                return;
            end
            if (pm == 0)
            begin
                err_flag = 0;
                return;
            end
            p  = pm << QBITS;
            q  = (p + am - 1) / am;
            t1 = floor_sqrt(q);
            if (t1 * t1 < q)
                t1++;
            if (vm < am * t1)
            begin
                if (vm == 0)
                begin
                    err_flag = 1;
                    return;
                end
                t1 = (vm + am - 1) / am;
                if (am * t1 * t1 < p)
                    t2 = (p - am * t1 * t1 + vm - 1) / vm;
            end
            if (t1 > (64'd1 << RAMP_BITS) - 1)
                t1 = (64'd1 << RAMP_BITS) - 1;
            if (t2 > (64'd1 << (RAMP_BITS + 1)) - 1)
                t2 = (64'd1 << (RAMP_BITS + 1)) - 1;
            den = t1 * t1 + t1 * t2;
            mag = (p + den / 2) / den;
            if (mag > 64'h7FFF_FFFF)
                mag = 64'h7FFF_FFFF;
            step_accel = distance[31] ? (32'h0 - mag[31:0]) : mag[31:0];
            ramp_len   = t1;
            cruise_len = t2;
            err_flag   = 0;
            moving     = 1;
        endfunction

        // called for every accepted input item
        function void note_item(item_kind_t kind, logic [31:0] distance,
                                logic [31:0] vlim, logic [31:0] alim);
            motion_sample_t s;
            logic [31:0] acc;
            if (kind == KIND_START)
            begin
                plan(distance, vlim, alim);
                return;
            end
            if (!moving)
            begin
                s.accel    = '0;
                s.velocity = velocity;
                s.position = position;
                s.last     = 0;
                s.idle     = 1;
                s.err      = err_flag;
                pending.push_back(s);
                return;
            end
            if (tick_index < ramp_len)
                acc = step_accel;
            else if (tick_index < ramp_len + cruise_len)
                acc = '0;
            else
                acc = 32'h0 - step_accel;
            velocity = velocity + {{16{acc[31]}}, acc};
            position = position + velocity;
            tick_index++;
            s.last = 0;
            if (tick_index >= 2 * ramp_len + cruise_len)
            begin
                s.last = 1;
                moving = 0;
            end
            s.accel    = acc;
            s.velocity = velocity;
            s.position = position;
            s.idle     = 0;
            s.err      = 0;
            pending.push_back(s);
        endfunction

        // called for every accepted output item
        function void check_sample(motion_sample_t got);
            motion_sample_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample: accel %h vel %h pos %h",
                             got.accel, got.velocity, got.position);
                return;
            end
            want = pending.pop_front();
            if (got.accel !== want.accel || got.velocity !== want.velocity ||
                got.position !== want.position || got.last !== want.last ||
                got.idle !== want.idle || got.err !== want.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"sample mismatch: exp a=%h v=%h p=%h l=%b i=%b e=%b,",
                              " got a=%h v=%h p=%h l=%b i=%b e=%b"},
                             want.accel, want.velocity, want.position, want.last,
                             want.idle, want.err, got.accel, got.velocity,
                             got.position, got.last, got.idle, got.err);
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [95:0]    s_tdata;    // distance, velocity_limit, accel_limit
    logic [0:0]     s_tuser;    // command
    logic           m_tvalid;
    logic           m_tready;
    logic [127:0]   m_tdata;    // accel_out, velocity_out, position_out
    logic [1:0]     m_tuser;    // idle, error
    logic           m_tlast;    // last_sample

    profile_scoreboard sb;
    int items_sent;
    bit stall_done;
    bit pause_done;

    trapezoid_profile_generator_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // output monitor
    always @(posedge clk)
    begin
        motion_sample_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.accel    = m_tdata[31:0];
            got.velocity = m_tdata[79:32];
            got.position = m_tdata[127:80];
            got.last     = m_tlast;
            got.idle     = m_tuser[0];
            got.err      = m_tuser[1];
            sb.check_sample(got);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off to back up the queue
    initial
    begin
        int n;
        m_tready   = 1'b0;
        stall_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!stall_done && items_sent >= 300)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                stall_done = 1;
                m_tready <= 1'b1;
            end
            else
            begin
                n = (items_sent > 600 && items_sent < 700) ? 0 : gap_len();
                if (n == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    // offer one item and hold it until accepted; called just after a negedge
    task automatic send_item(item_kind_t kind, logic [31:0] distance,
                             logic [31:0] vlim, logic [31:0] alim);
        int g;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {alim, vlim, distance};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(kind, distance, vlim, alim);
        items_sent++;
        @(negedge clk);
        g = (items_sent > 600 && items_sent < 700) ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic tick_n(int n);
        repeat (n)
            send_item(KIND_TICK, $urandom, $urandom, $urandom);
    endtask

    function automatic logic [31:0] signed_rand(int unsigned lo, int unsigned hi);
        logic [31:0] m;
        m = $urandom_range(hi, lo);
        return $urandom_range(0, 1) ? (32'h0 - m) : m;
    endfunction

    // one move with random or edge-case fields, ticked partly, to the end or past it
    task automatic random_move();
        logic [31:0] d, v, a;
        int r;
        longint unsigned left;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            d = $urandom;
            v = $urandom;
            a = $urandom;
        end
        else if (r < 16)
        begin
            d = signed_rand(0, 3);
            v = signed_rand(0, 2);
            a = signed_rand(0, 2);
        end
        else
        begin
            d = signed_rand(1, 1 << $urandom_range(1, 12));
            a = signed_rand(1 << 12, 1 << $urandom_range(13, 24));
            v = signed_rand(1 << 10, 1 << $urandom_range(12, 22));
        end
        send_item(KIND_START, d, v, a);
        left = sb.ticks_left();
        if (left <= 60 && $urandom_range(0, 99) < 70)
            tick_n(int'(left) + $urandom_range(0, 2));
        else
            tick_n($urandom_range(0, 25));
    endtask

    initial
    begin
        sb         = new();
        items_sent = 0;
        pause_done = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = KIND_TICK;
        s_tdata    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed cases
        tick_n(1);                                              // idle after reset
        send_item(KIND_START, 32'd0, 32'd100, 32'd0);           // zero accel, zero dist
        tick_n(1);
        send_item(KIND_START, 32'd0, 32'd100, 32'd5);           // zero distance clears error
        tick_n(1);
        send_item(KIND_START, 32'd100, 32'd0, 32'h0001_0000);   // zero velocity limit
        tick_n(1);
        send_item(KIND_START, -32'sd40, -32'sd196608, -32'sd65536);
        tick_n(int'(sb.ticks_left()) + 1);
        send_item(KIND_START, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        tick_n(3);                                              // restart while moving
        send_item(KIND_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1); // count saturation
        tick_n(2);
        send_item(KIND_START, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // minimal distance, highest limits
        tick_n(int'(sb.ticks_left()));
        send_item(KIND_START, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        tick_n(3);

        // random moves, with one pause until the output drains
        while (items_sent < 1000)
        begin
            random_move();
            if (!pause_done && items_sent >= 500)
            begin
                pause_done = 1;
                s_tvalid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("trapezoid_profile_generator_core test passed");
        else
            $display("trapezoid_profile_generator_core test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #40ms;
        $display("trapezoid_profile_generator_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
